[rtl/rgbbox_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbbox_pkg
// Shared constants for the RGB to gray 3x3 box filter: field widths,
// register indexes, reset values and fixed-point coefficients.
// ----------------------------------------------------------------------------
package rgbbox_pkg;

	// default size limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// field widths
	localparam int PIX_W      = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_COL_W  = 10;
	localparam int OUT_ROW_W  = 12;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int REG_WIDTH_W  = 11;
	localparam int REG_HEIGHT_W = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// register reset values
	localparam logic [REG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [REG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

	// luma weights, sum of weights is 256
	localparam int LUMA_SUM_W = 16;
	localparam logic [7:0] LUMA_R = 8'd77;
	localparam logic [7:0] LUMA_G = 8'd150;
	localparam logic [7:0] LUMA_B = 8'd29;

	// column sum of three pixels, window sum of nine
	localparam int COLSUM_W = 10;
	localparam int WINSUM_W = 12;

	// floor(x/9) = (x * 7282) >> 16, exact for x up to 9*255
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
	localparam int DIV9_SHIFT = 16;

endpackage
`default_nettype wire

[rtl/rgbbox_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbbox_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data. Read during write returns old data.
// ----------------------------------------------------------------------------
module rgbbox_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/rgb_gray_box_filter_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_gray_box_filter_3x3
// RGB raster pixels to 8-bit gray, then a 3x3 box mean over two line stores.
// Border pixels pass their own gray value; interior results come out when
// the lower-right neighbor arrives, tagged with their coordinates.
// ----------------------------------------------------------------------------
//  channel | dir | word                                      | side bits
//  --------+-----+-------------------------------------------+-------------------
//  s_*     | in  | tdata: red, green, blue                   | -
//  m_*     | out | tdata: filtered_gray, out_col, out_row    | tlast: last_of_run
//          |     |                                           | tuser: frame_done
//  wr_*    | in  | wr_data to register wr_index              | wr_en strobe
//
// One pixel per clock is accepted while m_* does not stall. A word reaches m_*
// through the stage 1, stage 2 and output registers: stage 1 takes the line
// store data and sums the window, stage 2 divides by nine into the output
// register. A pixel with two results (right column from row two on, bottom row
// from column two on) holds the input until the output register takes both.
// Reset clears counters, window and pipeline; line stores are not cleared.
// Output stalls back up through the pipeline into s_tready.
// ----------------------------------------------------------------------------
module rgb_gray_box_filter_3x3 #(
	parameter int MAX_WIDTH  = rgbbox_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rgbbox_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// pixel input
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [rgbbox_pkg::IN_DATA_W-1:0]    s_tdata,  // red, green, blue
	// result output
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [rgbbox_pkg::OUT_DATA_W-1:0]   m_tdata,  // gray, col, row, 2'b0
	output logic                                     m_tlast,  // last_of_run
	output logic                                     m_tuser,  // frame_done
	// register write
	input  wire logic                                wr_en,
	input  wire logic [rgbbox_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [rgbbox_pkg::CFG_W-1:0]        wr_data
);

	import rgbbox_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PROD_W = WINSUM_W + RECIP_W;

	// configuration and counters
	logic [REG_WIDTH_W-1:0]  image_width_q;
	logic [REG_HEIGHT_W-1:0] image_height_q;
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;
	logic [31:0]             w_raw, h_raw, w_clamp, h_clamp;
	logic [CW-1:0]           wlast;
	logic [RW-1:0]           hlast;

	// input stage
	logic                    accept;
	logic                    adv;
	logic [LUMA_SUM_W-1:0]   luma_sum;
	logic [PIX_W-1:0]        gray_in;
	logic                    col_end, row_end;

	// stage 1: line store data back, window update
	logic                    valid_s1;
	logic [PIX_W-1:0]        gray_s1;
	logic [CW-1:0]           c_s1;
	logic [RW-1:0]           y_s1;
	logic                    inner_s1, border_s1, lastpix_s1;
	logic                    fwd_s1;
	logic [PIX_W-1:0]        fwd_up_s1, fwd_mid_s1;
	logic [PIX_W-1:0]        up_rd, mid_rd, up_val, mid_val;
	logic [COLSUM_W-1:0]     cs1_q, cs2_q, cs_new;
	logic [WINSUM_W-1:0]     win_sum;
	logic                    wr_s1;

	// stage 2: divide and emit
	logic [WINSUM_W-1:0]     sum_s2;
	logic [PIX_W-1:0]        gray_s2;
	logic [CW-1:0]           c_s2;
	logic [RW-1:0]           y_s2;
	logic                    inner_s2, border_s2, lastpix_s2;
	logic [PROD_W-1:0]       prod;
	logic [PIX_W-1:0]        quot;
	logic                    out_free;
	logic                    s2_done;

	// output register
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_gray_q;
	logic [OUT_COL_W-1:0]    out_col_q;
	logic [OUT_ROW_W-1:0]    out_row_q;
	logic                    out_last_q, out_done_q;

	// clamp frame size to 1..MAX
	always_comb begin
		w_raw = 32'(image_width_q);
		h_raw = 32'(image_height_q);
		if (w_raw == 32'd0) begin
			w_clamp = 32'd1;
		end else if (w_raw > 32'(MAX_WIDTH)) begin
			w_clamp = 32'(MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
		if (h_raw == 32'd0) begin
			h_clamp = 32'd1;
		end else if (h_raw > 32'(MAX_HEIGHT)) begin
			h_clamp = 32'(MAX_HEIGHT);
		end else begin
			h_clamp = h_raw;
		end
		wlast = CW'(w_clamp - 32'd1);
		hlast = RW'(h_clamp - 32'd1);
	end

	// handshake: whole pipe moves when stage 2 can take a new pixel
	assign out_free = !out_valid_q || m_tready;
	assign s2_done  = (!inner_s2 && !border_s2) || (out_free && !(inner_s2 && border_s2));
	assign adv      = s2_done;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign wr_s1    = adv && valid_s1;

	// luma
	assign luma_sum = LUMA_SUM_W'(s_tdata[7:0]) * LUMA_SUM_W'(LUMA_R)
	                + LUMA_SUM_W'(s_tdata[15:8]) * LUMA_SUM_W'(LUMA_G)
	                + LUMA_SUM_W'(s_tdata[23:16]) * LUMA_SUM_W'(LUMA_B);
	assign gray_in  = luma_sum[LUMA_SUM_W-1 -: PIX_W];

	assign col_end = (col_q >= wlast);
	assign row_end = (row_q >= hlast);

	// line stores: read at accept, written back when the pixel leaves stage 1
	rgbbox_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_ram_upper (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(c_s1),
		.wdata(mid_val),
		.re   (accept),
		.raddr(col_q),
		.rdata(up_rd)
	);

	rgbbox_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_ram_middle (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(c_s1),
		.wdata(gray_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(mid_rd)
	);

	// forward the write that raced the read (one-pixel-wide frame)
	assign up_val  = fwd_s1 ? fwd_up_s1 : up_rd;
	assign mid_val = fwd_s1 ? fwd_mid_s1 : mid_rd;

	// window kept as column sums; newest column enters here
	assign cs_new  = COLSUM_W'(up_val) + COLSUM_W'(mid_val) + COLSUM_W'(gray_s1);
	assign win_sum = WINSUM_W'(cs1_q) + WINSUM_W'(cs2_q) + WINSUM_W'(cs_new);

	// divide by nine
	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV9_RECIP);
	assign quot = prod[DIV9_SHIFT +: PIX_W];

	// config, counters, window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			col_q          <= '0;
			row_q          <= '0;
			cs1_q          <= '0;
			cs2_q          <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:  image_width_q  <= wr_data[REG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= wr_data[REG_HEIGHT_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
			cs1_q <= '0;
			cs2_q <= '0;
		end else begin
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (wr_s1) begin
				cs1_q <= cs2_q;
				cs2_q <= cs_new;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1    <= gray_in;
			c_s1       <= col_q;
			y_s1       <= row_q;
			inner_s1   <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			border_s1  <= (col_q == '0) || (row_q == '0) || col_end || row_end;
			lastpix_s1 <= col_end && row_end;
			fwd_s1     <= valid_s1 && (c_s1 == col_q);
			fwd_up_s1  <= mid_val;
			fwd_mid_s1 <= gray_s1;
		end
	end

	// stage 2 pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_s2  <= 1'b0;
			border_s2 <= 1'b0;
		end else if (adv) begin
			inner_s2  <= valid_s1 && inner_s1;
			border_s2 <= valid_s1 && border_s1;
		end else if (out_free) begin
			// two pending: inner result goes first
			inner_s2 <= 1'b0;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2     <= win_sum;
			gray_s2    <= gray_s1;
			c_s2       <= c_s1;
			y_s2       <= y_s1;
			lastpix_s2 <= lastpix_s1;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= inner_s2 || border_s2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			priority if (inner_s2) begin
				out_gray_q <= quot;
				out_col_q  <= OUT_COL_W'(c_s2 - CW'(1));
				out_row_q  <= OUT_ROW_W'(y_s2 - RW'(1));
				out_last_q <= !border_s2;
				out_done_q <= 1'b0;
			end else if (border_s2) begin
				out_gray_q <= gray_s2;
				out_col_q  <= OUT_COL_W'(c_s2);
				out_row_q  <= OUT_ROW_W'(y_s2);
				out_last_q <= 1'b1;
				out_done_q <= lastpix_s2;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_row_q, out_col_q, out_gray_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

endmodule
`default_nettype wire
